@@ hdl/xlsu_pkg.sv @@
// Shared types, codes and helper functions of the logic and shift execute unit.
package xlsu_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;

	localparam logic [3:0] OP_TEST  = 4'd0;
	localparam logic [3:0] OP_AND   = 4'd1;
	localparam logic [3:0] OP_XOR   = 4'd2;
	localparam logic [3:0] OP_OR    = 4'd3;
	localparam logic [3:0] OP_SAR   = 4'd4;
	localparam logic [3:0] OP_SHL   = 4'd5;
	localparam logic [3:0] OP_SHR   = 4'd6;
	localparam logic [3:0] OP_ROL   = 4'd7;
	localparam logic [3:0] OP_SETCC = 4'd8;
	localparam logic [3:0] OP_NOT   = 4'd9;

	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_WORD  = 2'd1;
	localparam logic [1:0] SIZE_DWORD = 2'd2;

	localparam logic [3:0] CC_P  = 4'd10;
	localparam logic [3:0] CC_NP = 4'd11;

	localparam logic [2:0] CC_GRP_O  = 3'd0;
	localparam logic [2:0] CC_GRP_B  = 3'd1;
	localparam logic [2:0] CC_GRP_E  = 3'd2;
	localparam logic [2:0] CC_GRP_BE = 3'd3;
	localparam logic [2:0] CC_GRP_S  = 3'd4;
	localparam logic [2:0] CC_GRP_L  = 3'd6;
	localparam logic [2:0] CC_GRP_LE = 3'd7;

	typedef struct packed {
		logic cf;
		logic of;
		logic zf;
		logic sf;
	} flags_t;

	typedef struct packed {
		logic [3:0]       op;
		logic [1:0]       size_code;
		logic [DATA_W-1:0] d;
		logic [DATA_W-1:0] sx;
		logic [DATA_W-1:0] src;
		logic [CNT_W-1:0]  cnt;
		logic [CNT_W-1:0]  rot;
		logic [3:0]       cond_code;
		flags_t           flags;
	} s1_t;

	typedef struct packed {
		logic [3:0]       op;
		logic [1:0]       size_code;
		logic [DATA_W-1:0] res;
		logic             wr;
		logic             uns;
		logic             cnt_nz;
		flags_t           flags;
	} s2_t;

	typedef struct packed {
		logic [1:0]       size_code;
		logic [DATA_W-1:0] res;
		logic             wr;
		logic             uns;
		flags_t           flags;
	} s3_t;

	function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sc);
		case (sc)
			SIZE_BYTE: size_mask = 32'h0000_00ff;
			SIZE_WORD: size_mask = 32'h0000_ffff;
			default:   size_mask = 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic top_bit(input logic [DATA_W-1:0] v, input logic [1:0] sc);
		case (sc)
			SIZE_BYTE: top_bit = v[7];
			SIZE_WORD: top_bit = v[15];
			default:   top_bit = v[31];
		endcase
	endfunction

	function automatic logic cond_true(input logic [3:0] cc, input flags_t f);
		logic base;
		case (cc[3:1])
			CC_GRP_O:  base = f.of;
			CC_GRP_B:  base = f.cf;
			CC_GRP_E:  base = f.zf;
			CC_GRP_BE: base = f.cf | f.zf;
			CC_GRP_S:  base = f.sf;
			CC_GRP_L:  base = f.sf ^ f.of;
			CC_GRP_LE: base = f.zf | (f.sf ^ f.of);
			default:   base = 1'b0;
		endcase
		cond_true = base ^ cc[0];
	endfunction

endpackage

@@ hdl/xlsu_if.sv @@
// Handshake interfaces for the instruction and result channels of the execute unit.
interface xlsu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [1:0]  size_code;
	logic [31:0] dest_value;
	logic [31:0] src_value;
	logic [3:0]  cond_code;
	logic        carry_in;
	logic        overflow_in;
	logic        zero_in;
	logic        sign_in;

	modport source (
		output valid, op, size_code, dest_value, src_value, cond_code,
		output carry_in, overflow_in, zero_in, sign_in,
		input  ready
	);
	modport sink (
		input  valid, op, size_code, dest_value, src_value, cond_code,
		input  carry_in, overflow_in, zero_in, sign_in,
		output ready
	);
endinterface

interface xlsu_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_value;
	logic        write_dest;
	logic        carry_out;
	logic        overflow_out;
	logic        zero_out;
	logic        sign_out;
	logic        unsupported;

	modport source (
		output valid, result_value, write_dest, carry_out, overflow_out,
		output zero_out, sign_out, unsupported,
		input  ready
	);
	modport sink (
		input  valid, result_value, write_dest, carry_out, overflow_out,
		input  zero_out, sign_out, unsupported,
		output ready
	);
endinterface

@@ hdl/x86_logic_shift_unit.sv @@
// Top level of the pipelined logic, shift and rotate execute unit.
//
// Channel | Role                 | Transaction
// --------+----------------------+----------------------------------------------
// req     | sink, valid/ready    | opcode, size, operands, condition, flags in
// rsp     | source, valid/ready  | sized result, write enable, flags, unsupported
//
// Every transaction passes through the pipe registers in order: operand sizing, the
// barrel shifter and logic stage, then flag generation into the output register.
// One transaction is accepted per cycle while the result channel keeps up.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stage holds its contents while the stage after it is full and stalled, so
// bubbles are squeezed out and nothing is lost or repeated.
module x86_logic_shift_unit (
	input logic       clk,
	input logic       arst_n,
	xlsu_req_if.sink  req,
	xlsu_rsp_if.source rsp
);
	import xlsu_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	s1_t  p_s1;
	s2_t  p_s2;
	s3_t  p_s3;
	s1_t  s1_next;
	s2_t  s2_next;
	s3_t  s3_next;
	logic [DATA_W-1:0] in_mask;
	logic [DATA_W-1:0] in_d;
	logic [CNT_W-1:0]  in_cnt;

	assign adv3      = rsp.ready || !v_s3;
	assign adv2      = adv3 || !v_s2;
	assign adv1      = adv2 || !v_s1;
	assign req.ready = adv1;

	assign in_mask = size_mask(req.size_code);
	assign in_d    = req.dest_value & in_mask;
	assign in_cnt  = req.src_value[CNT_W-1:0];

	always_comb begin
		s1_next.op        = req.op;
		s1_next.size_code = req.size_code;
		s1_next.d         = in_d;
		s1_next.sx        = top_bit(in_d, req.size_code) ? (in_d | ~in_mask) : in_d;
		s1_next.src       = req.src_value;
		s1_next.cnt       = in_cnt;
		case (req.size_code)
			SIZE_BYTE: s1_next.rot = {2'b00, in_cnt[2:0]};
			SIZE_WORD: s1_next.rot = {1'b0, in_cnt[3:0]};
			default:   s1_next.rot = in_cnt;
		endcase
		s1_next.cond_code = req.cond_code;
		s1_next.flags     = '{cf: req.carry_in, of: req.overflow_in,
			zf: req.zero_in, sf: req.sign_in};
	end

	xlsu_exec u_exec (
		.s1 (p_s1),
		.s2 (s2_next)
	);

	always_comb begin
		s3_next.size_code = p_s2.size_code;
		s3_next.res       = p_s2.res;
		s3_next.wr        = p_s2.wr;
		s3_next.uns       = p_s2.uns;
		s3_next.flags     = p_s2.flags;
		if (p_s2.op inside {[OP_TEST:OP_SHR]}) begin
			s3_next.flags.zf = (p_s2.res == '0);
			s3_next.flags.sf = top_bit(p_s2.res, p_s2.size_code);
			if (p_s2.op inside {[OP_TEST:OP_OR]}) begin
				s3_next.flags.cf = 1'b0;
				s3_next.flags.of = 1'b0;
			end
		end else if (p_s2.op == OP_ROL && p_s2.cnt_nz) begin
			s3_next.flags.cf = p_s2.res[0];
			s3_next.flags.of = top_bit(p_s2.res, p_s2.size_code) ^ p_s2.res[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) p_s1 <= s1_next;
		if (adv2) p_s2 <= s2_next;
		if (adv3) p_s3 <= s3_next;
	end

	assign rsp.valid        = v_s3;
	assign rsp.result_value = p_s3.res;
	assign rsp.write_dest   = p_s3.wr;
	assign rsp.carry_out    = p_s3.flags.cf;
	assign rsp.overflow_out = p_s3.flags.of;
	assign rsp.zero_out     = p_s3.flags.zf;
	assign rsp.sign_out     = p_s3.flags.sf;
	assign rsp.unsupported  = p_s3.uns;

	a_backpressure_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (v_s1 && v_s2 && v_s3))
		else $error("Input stalled while the pipeline has a free stage.");

	a_unsupported_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.unsupported) |-> (!rsp.write_dest && rsp.result_value == '0))
		else $error("Unsupported condition produced a written result.");

	a_byte_result_sized: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && p_s3.size_code == SIZE_BYTE) |-> (p_s3.res[DATA_W-1:8] == '0))
		else $error("Byte-sized result has bits set above the operand size.");

endmodule

@@ hdl/xlsu_exec.sv @@
// Second-stage datapath: logic operations including not, barrel shifts, sized rotate and setcc.
module xlsu_exec (
	input  xlsu_pkg::s1_t s1,
	output xlsu_pkg::s2_t s2
);
	import xlsu_pkg::*;

	logic [DATA_W-1:0]   mask;
	logic [DATA_W-1:0]   rep;
	logic [2*DATA_W-1:0] rot_wide;
	logic [DATA_W-1:0]   sar_v;
	logic [DATA_W-1:0]   res;
	logic                wr;
	logic                uns;

	assign mask = size_mask(s1.size_code);

	always_comb begin
		case (s1.size_code)
			SIZE_BYTE: rep = {4{s1.d[7:0]}};
			SIZE_WORD: rep = {2{s1.d[15:0]}};
			default:   rep = s1.d;
		endcase
	end

	assign rot_wide = {rep, rep} << s1.rot;
	assign sar_v    = DATA_W'($signed(s1.sx) >>> s1.cnt);

	always_comb begin
		res = '0;
		wr  = 1'b0;
		uns = 1'b0;
		case (s1.op)
			OP_TEST, OP_AND: begin
				res = s1.d & s1.src & mask;
				wr  = (s1.op == OP_AND);
			end
			OP_XOR: begin
				res = (s1.d ^ s1.src) & mask;
				wr  = 1'b1;
			end
			OP_OR: begin
				res = (s1.d | s1.src) & mask;
				wr  = 1'b1;
			end
			OP_SAR: begin
				res = sar_v & mask;
				wr  = 1'b1;
			end
			OP_SHL: begin
				res = (s1.d << s1.cnt) & mask;
				wr  = 1'b1;
			end
			OP_SHR: begin
				res = s1.d >> s1.cnt;
				wr  = 1'b1;
			end
			OP_ROL: begin
				res = rot_wide[2*DATA_W-1:DATA_W] & mask;
				wr  = 1'b1;
			end
			OP_SETCC: begin
				if (s1.cond_code inside {CC_P, CC_NP}) begin
					uns = 1'b1;
				end else begin
					res = {{(DATA_W-1){1'b0}}, cond_true(s1.cond_code, s1.flags)};
					wr  = 1'b1;
				end
			end
			OP_NOT: begin
				res = ~s1.d & mask;
				wr  = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_comb begin
		s2.op        = s1.op;
		s2.size_code = s1.size_code;
		s2.res       = res;
		s2.wr        = wr;
		s2.uns       = uns;
		s2.cnt_nz    = (s1.cnt != '0);
		s2.flags     = s1.flags;
	end
endmodule

@@ test/x86_logic_shift_unit_tb.sv @@
// Self-checking testbench for the logic, shift and rotate execute unit.
`timescale 1ns / 1ps

module x86_logic_shift_unit_tb;
	import xlsu_pkg::*;

	localparam logic [1:0] SIZE_ALIAS_DWORD = 2'd3;
	localparam logic [3:0] OP_UNDEF_LO      = 4'd10;
	localparam logic [3:0] OP_UNDEF_HI      = 4'd15;
	localparam int         ITEMS_PER_PHASE  = 420;
	localparam int         CYCLE_LIMIT      = 400000;
	localparam int         REPORT_LIMIT     = 10;

	typedef struct packed {
		logic [3:0]  op;
		logic [1:0]  size_code;
		logic [31:0] dest;
		logic [31:0] src;
		logic [3:0]  cc;
		logic        cf;
		logic        of;
		logic        zf;
		logic        sf;
	} alu_instr_t;

	typedef struct packed {
		logic [31:0] value;
		logic        wr;
		logic        cf;
		logic        of;
		logic        zf;
		logic        sf;
		logic        uns;
	} alu_outcome_t;

	class alu_scoreboard;
		alu_outcome_t pending_outcomes[$];
		int           n_errors;
		int           n_checked;

		function new();
			n_errors  = 0;
			n_checked = 0;
		endfunction

		function logic [31:0] width_mask(logic [1:0] sc);
			case (sc)
				SIZE_BYTE: return 32'h0000_00ff;
				SIZE_WORD: return 32'h0000_ffff;
				default:   return 32'hffff_ffff;
			endcase
		endfunction

		function int width_bits(logic [1:0] sc);
			case (sc)
				SIZE_BYTE: return 8;
				SIZE_WORD: return 16;
				default:   return 32;
			endcase
		endfunction

		function logic condition_holds(logic [3:0] cc, logic cf, logic of, logic zf, logic sf);
			logic base;
			case (cc[3:1])
				CC_GRP_O:  base = of;
				CC_GRP_B:  base = cf;
				CC_GRP_E:  base = zf;
				CC_GRP_BE: base = cf | zf;
				CC_GRP_S:  base = sf;
				CC_GRP_L:  base = sf ^ of;
				CC_GRP_LE: base = zf | (sf ^ of);
				default:   base = 1'b0;
			endcase
			return base ^ cc[0];
		endfunction

		function alu_outcome_t compute_outcome(alu_instr_t it);
			alu_outcome_t o;
			logic [31:0]  mask;
			logic [31:0]  d;
			logic [31:0]  sx;
			logic [4:0]   cnt;
			int           bits;
			int           r;
			logic         upd_zs;
			mask   = width_mask(it.size_code);
			bits   = width_bits(it.size_code);
			d      = it.dest & mask;
			cnt    = it.src[4:0];
			upd_zs = 1'b0;
			o      = '0;
			o.cf   = it.cf;
			o.of   = it.of;
			o.zf   = it.zf;
			o.sf   = it.sf;
			case (it.op)
				OP_TEST, OP_AND, OP_XOR, OP_OR: begin
					if (it.op == OP_XOR)
						o.value = (d ^ it.src) & mask;
					else if (it.op == OP_OR)
						o.value = (d | it.src) & mask;
					else
						o.value = d & it.src & mask;
					o.wr   = (it.op != OP_TEST);
					o.cf   = 1'b0;
					o.of   = 1'b0;
					upd_zs = 1'b1;
				end
				OP_SAR: begin
					sx = d;
					if (d[bits-1] && bits < 32)
						sx = d | ~mask;
					sx      = $signed(sx) >>> cnt;
					o.value = sx & mask;
					o.wr    = 1'b1;
					upd_zs  = 1'b1;
				end
				OP_SHL: begin
					o.value = (d << cnt) & mask;
					o.wr    = 1'b1;
					upd_zs  = 1'b1;
				end
				OP_SHR: begin
					o.value = d >> cnt;
					o.wr    = 1'b1;
					upd_zs  = 1'b1;
				end
				OP_ROL: begin
					r = int'(cnt) & (bits - 1);
					if (r == 0)
						o.value = d;
					else
						o.value = ((d << r) | (d >> (bits - r))) & mask;
					o.wr = 1'b1;
					if (cnt != 5'd0) begin
						o.cf = o.value[0];
						o.of = o.value[bits-1] ^ o.value[0];
					end
				end
				OP_SETCC: begin
					if (it.cc == CC_P || it.cc == CC_NP) begin
						o.uns = 1'b1;
					end else begin
						o.value = {31'd0, condition_holds(it.cc, it.cf, it.of, it.zf, it.sf)};
						o.wr    = 1'b1;
					end
				end
				OP_NOT: begin
					o.value = ~d & mask;
					o.wr    = 1'b1;
				end
				default: begin
				end
			endcase
			if (upd_zs) begin
				o.zf = (o.value == 32'd0);
				o.sf = o.value[bits-1];
			end
			return o;
		endfunction

		function void note_instruction(alu_instr_t it);
			pending_outcomes.push_back(compute_outcome(it));
		endfunction

		function void check_outcome(alu_outcome_t got);
			alu_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				n_errors++;
				if (n_errors <= REPORT_LIMIT)
					$display("Unexpected result transaction: value %h wr %b flags %b%b%b%b uns %b",
						got.value, got.wr, got.cf, got.of, got.zf, got.sf, got.uns);
				return;
			end
			want = pending_outcomes.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				if (n_errors <= REPORT_LIMIT) begin
					$display("Result mismatch, expected: value %h wr %b cf %b of %b zf %b sf %b uns %b",
						want.value, want.wr, want.cf, want.of, want.zf, want.sf, want.uns);
					$display("                 actual:   value %h wr %b cf %b of %b zf %b sf %b uns %b",
						got.value, got.wr, got.cf, got.of, got.zf, got.sf, got.uns);
				end
			end
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	xlsu_req_if req_if ();
	xlsu_rsp_if rsp_if ();

	x86_logic_shift_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	alu_scoreboard sb = new();
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            cycle_count   = 0;
	int            n_directed    = 0;
	int            n_random      = 0;
	int            op_seen[16];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, sb.pending());
			$display("x86_logic_shift_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		alu_outcome_t got;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got.value = rsp_if.result_value;
				got.wr    = rsp_if.write_dest;
				got.cf    = rsp_if.carry_out;
				got.of    = rsp_if.overflow_out;
				got.zf    = rsp_if.zero_out;
				got.sf    = rsp_if.sign_out;
				got.uns   = rsp_if.unsupported;
				sb.check_outcome(got);
			end
			rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_instruction(input alu_instr_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.op          <= it.op;
		req_if.size_code   <= it.size_code;
		req_if.dest_value  <= it.dest;
		req_if.src_value   <= it.src;
		req_if.cond_code   <= it.cc;
		req_if.carry_in    <= it.cf;
		req_if.overflow_in <= it.of;
		req_if.zero_in     <= it.zf;
		req_if.sign_in     <= it.sf;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_instruction(it);
		op_seen[it.op]++;
	endtask

	task automatic send_directed(input logic [3:0] op, input logic [1:0] sc,
			input logic [31:0] dest, input logic [31:0] src, input logic [3:0] cc,
			input logic [3:0] flags);
		alu_instr_t it;
		it.op        = op;
		it.size_code = sc;
		it.dest      = dest;
		it.src       = src;
		it.cc        = cc;
		{it.cf, it.of, it.zf, it.sf} = flags;
		send_instruction(it);
		n_directed++;
	endtask

	task automatic drain_pipeline();
		req_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0:       return 32'h0000_0000;
			1:       return 32'hffff_ffff;
			2:       return 32'h8000_0000 >> $urandom_range(31);
			3:       return ~(32'h8000_0000 >> $urandom_range(31));
			4:       return $urandom & 32'h0000_00ff;
			default: return $urandom;
		endcase
	endfunction

	function automatic alu_instr_t random_instruction();
		alu_instr_t it;
		if ($urandom_range(99) < 6)
			it.op = 4'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
		else
			it.op = 4'($urandom_range(OP_NOT, OP_TEST));
		if ($urandom_range(99) < 6)
			it.size_code = SIZE_ALIAS_DWORD;
		else
			it.size_code = 2'($urandom_range(SIZE_DWORD, SIZE_BYTE));
		it.dest = pick_operand();
		it.src  = pick_operand();
		if (it.op == OP_SAR || it.op == OP_SHL || it.op == OP_SHR || it.op == OP_ROL) begin
			if ($urandom_range(3) == 0)
				it.src = ($urandom & 32'hffff_ffe0) | $urandom_range(31);
			else if ($urandom_range(5) == 0)
				it.src[4:0] = 5'd0;
		end
		it.cc = 4'($urandom_range(15));
		{it.cf, it.of, it.zf, it.sf} = 4'($urandom_range(15));
		return it;
	endfunction

	task automatic run_random_phase(input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (ITEMS_PER_PHASE) begin
			send_instruction(random_instruction());
			n_random++;
		end
		drain_pipeline();
	endtask

	initial begin
		int n_ops;
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.op          = OP_TEST;
		req_if.size_code   = SIZE_BYTE;
		req_if.dest_value  = '0;
		req_if.src_value   = '0;
		req_if.cond_code   = '0;
		req_if.carry_in    = 1'b0;
		req_if.overflow_in = 1'b0;
		req_if.zero_in     = 1'b0;
		req_if.sign_in     = 1'b0;
		foreach (op_seen[i])
			op_seen[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 84;
		send_directed(OP_AND,   SIZE_DWORD, 32'hffff_ffff, 32'hffff_ffff, '0, 4'b1111);
		send_directed(OP_AND,   SIZE_BYTE,  32'h1234_5600, 32'hffff_ffff, '0, 4'b1100);
		send_directed(OP_TEST,  SIZE_WORD,  32'hffff_8001, 32'h0000_8000, '0, 4'b1111);
		send_directed(OP_XOR,   SIZE_WORD,  32'h0000_abcd, 32'hffff_abcd, '0, 4'b0000);
		send_directed(OP_OR,    SIZE_BYTE,  32'h0000_0000, 32'h0000_0080, '0, 4'b1111);
		send_directed(OP_SAR,   SIZE_BYTE,  32'h0000_0080, 32'h0000_0007, '0, 4'b1010);
		send_directed(OP_SAR,   SIZE_DWORD, 32'h8000_0000, 32'hffff_ffff, '0, 4'b0101);
		send_directed(OP_SAR,   SIZE_WORD,  32'h0000_7fff, 32'h0000_0000, '0, 4'b1111);
		send_directed(OP_SHL,   SIZE_DWORD, 32'h0000_0001, 32'h0000_001f, '0, 4'b1100);
		send_directed(OP_SHL,   SIZE_BYTE,  32'h0000_00ff, 32'h0000_0008, '0, 4'b0011);
		send_directed(OP_SHR,   SIZE_ALIAS_DWORD, 32'hffff_ffff, 32'hffff_ffe0, '0, 4'b1001);
		send_directed(OP_SHR,   SIZE_WORD,  32'h0000_8000, 32'h0000_000f, '0, 4'b0110);
		send_directed(OP_ROL,   SIZE_BYTE,  32'h0000_0081, 32'h0000_0008, '0, 4'b0000);
		send_directed(OP_ROL,   SIZE_WORD,  32'h0000_8001, 32'h0000_0000, '0, 4'b1111);
		send_directed(OP_ROL,   SIZE_WORD,  32'h0000_c000, 32'h0000_0001, '0, 4'b0000);
		send_directed(OP_ROL,   SIZE_DWORD, 32'h8000_0001, 32'h0000_001f, '0, 4'b0000);
		send_directed(OP_SETCC, SIZE_BYTE,  '0, '0, {CC_GRP_E, 1'b0},  4'b0010);
		send_directed(OP_SETCC, SIZE_BYTE,  '0, '0, {CC_GRP_LE, 1'b1}, 4'b0101);
		send_directed(OP_SETCC, SIZE_BYTE,  '0, '0, CC_P,  4'b1111);
		send_directed(OP_SETCC, SIZE_BYTE,  '0, '0, CC_NP, 4'b0000);
		send_directed(OP_NOT,   SIZE_BYTE,  32'hffff_ff00, '0, '0, 4'b1010);
		send_directed(OP_NOT,   SIZE_DWORD, 32'h0000_0000, '0, '0, 4'b0101);
		send_directed(OP_UNDEF_HI, SIZE_DWORD, 32'hffff_ffff, 32'hffff_ffff, 4'hf, 4'b1111);
		send_directed(OP_UNDEF_LO, SIZE_WORD,  32'h1234_5678, 32'h0000_0003, '0, 4'b0110);
		drain_pipeline();

		run_random_phase(18, 84);
		run_random_phase(84, 18);
		run_random_phase(0, 0);

		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.n_errors++;
		n_ops = 0;
		foreach (op_seen[i])
			if (op_seen[i] != 0)
				n_ops++;
		$display("Covered %0d directed and %0d random transactions over %0d opcodes,",
			n_directed, n_random, n_ops);
		$display("all operand sizes, every condition code, both idling patterns; %0d checked.",
			sb.n_checked);
		if (sb.n_errors == 0) begin
			$display("x86_logic_shift_unit_tb OK");
		end else begin
			$display("%0d failures found.", sb.n_errors);
			$display("x86_logic_shift_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/xlsu_pkg.sv
hdl/xlsu_if.sv
hdl/xlsu_exec.sv
hdl/x86_logic_shift_unit.sv
test/x86_logic_shift_unit_tb.sv
